// File: design/bbst_pkg.sv
// Shared constants and types for the bounded byte set table.
package bbst_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int ACT_W    = 2;
	localparam int VAL_W    = 8;
	localparam int SIZE_W   = 5;

	typedef enum logic [ACT_W-1:0] {
		ACT_LOOKUP = 2'd0,
		ACT_ADD    = 2'd1,
		ACT_DELETE = 2'd2
	} action_t;

	typedef struct packed {
		logic load;
		logic match;
		logic apply;
	} ctrl_cmd_t;

endpackage

// File: design/bbst_if.sv
// Request and response channel interfaces of the bounded byte set table.
interface bbst_req_if;
	logic                      valid;
	logic                      ready;
	logic [bbst_pkg::ACT_W-1:0] action;
	logic [bbst_pkg::VAL_W-1:0] value;

	modport source (output valid, output action, output value, input ready);
	modport sink (input valid, input action, input value, output ready);
endinterface

interface bbst_rsp_if;
	logic                       valid;
	logic                       ready;
	logic                       was_present;
	logic                       changed;
	logic [bbst_pkg::SIZE_W-1:0] size_after;

	modport source (output valid, output was_present, output changed, output size_after,
		input ready);
	modport sink (input valid, input was_present, input changed, input size_after,
		output ready);
endinterface

// File: design/bounded_byte_set_table_unit.sv
// Top level of the bounded byte set table.
// Holds up to CAPACITY distinct byte values, packed in insertion order. Each request
// transaction (lookup, add, delete; code 3 behaves as lookup) yields one response
// transaction with prior presence, a changed flag and the count afterwards. A request
// passes through these steps from acceptance to response: it is registered, compared
// in parallel against all live entries, then appended or compacted while the
// response register is loaded. One request is in flight at a time; a new request is accepted
// while the previous response still waits, and only its final step waits for that
// response to be taken.
module bounded_byte_set_table_unit (
	input  logic clk,
	input  logic arst_n,
	bbst_req_if.sink   req,
	bbst_rsp_if.source rsp
);
	import bbst_pkg::*;

	ctrl_cmd_t cmd;

	bbst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	bbst_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.in_action   (req.action),
		.in_value    (req.value),
		.was_present (rsp.was_present),
		.changed     (rsp.changed),
		.size_after  (rsp.size_after)
	);

endmodule

// File: design/bbst_ctrl.sv
// Sequencing controller: accept, match, apply, response register handshake.
module bbst_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output bbst_pkg::ctrl_cmd_t cmd
);
	import bbst_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MATCH,
		S_APPLY
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free   = !out_valid_q || out_ready;
	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign cmd.load   = in_valid && in_ready;
	assign cmd.match  = (state_q == S_MATCH);
	assign cmd.apply  = (state_q == S_APPLY) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.apply) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_MATCH;
					end
				end
				S_MATCH: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_load_to_match: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.match)
		else $error("accepted transaction did not enter match");

	a_apply_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |=> out_valid_q)
		else $error("result not presented after apply");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |-> !(out_valid_q && !out_ready))
		else $error("pending result overwritten");

endmodule

// File: design/bbst_dpath.sv
// Datapath: element registers, parallel compare, append and compaction shift, result register.
module bbst_dpath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bbst_pkg::ctrl_cmd_t        cmd,
	input  logic [bbst_pkg::ACT_W-1:0] in_action,
	input  logic [bbst_pkg::VAL_W-1:0] in_value,
	output logic                       was_present,
	output logic                       changed,
	output logic [bbst_pkg::SIZE_W-1:0] size_after
);
	import bbst_pkg::*;

	logic [VAL_W-1:0]    store_q [CAPACITY];
	logic [CNT_W-1:0]    count_q;
	logic [ACT_W-1:0]    action_q;
	logic [VAL_W-1:0]    value_q;
	logic [CAPACITY-1:0] hit_c;
	logic [CAPACITY-1:0] hit_q;
	logic [CAPACITY-1:0] shift_c;
	logic [CAPACITY-1:0] shift_q;
	logic                present;
	logic                full;
	logic                do_add;
	logic                do_del;
	logic [CNT_W-1:0]    count_next;
	logic                was_present_q;
	logic                changed_q;
	logic [SIZE_W-1:0]   size_q;

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			hit_c[i] = (CNT_W'(i) < count_q) && (store_q[i] == value_q);
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_shift
		assign shift_c[g] = |hit_c[g:0];
	end

	assign present = |hit_q;
	assign full    = (count_q == CNT_W'(CAPACITY));

	always_comb begin
		do_add = 1'b0;
		do_del = 1'b0;
		unique case (action_q)
			ACT_ADD:    do_add = !present && !full;
			ACT_DELETE: do_del = present;
			default:    ;
		endcase
	end

	always_comb begin
		priority if (do_add) begin
			count_next = count_q + CNT_W'(1);
		end else if (do_del) begin
			count_next = count_q - CNT_W'(1);
		end else begin
			count_next = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.apply) begin
			count_q <= count_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= in_action;
			value_q  <= in_value;
		end
		if (cmd.match) begin
			hit_q   <= hit_c;
			shift_q <= shift_c;
		end
		if (cmd.apply) begin
			was_present_q <= present;
			changed_q     <= do_add || do_del;
			size_q        <= SIZE_W'(count_next);
			if (do_add) begin
				store_q[count_q[IDX_W-1:0]] <= value_q;
			end
			if (do_del) begin
				for (int i = 0; i < CAPACITY - 1; i++) begin
					if (shift_q[i]) begin
						store_q[i] <= store_q[i+1];
					end
				end
			end
		end
	end

	assign was_present = was_present_q;
	assign changed     = changed_q;
	assign size_after  = size_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("element count beyond capacity");

	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.match |=> $onehot0(hit_q))
		else $error("value matched more than one entry");

	a_size_tracks_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |=> (size_q == SIZE_W'(count_q)))
		else $error("reported size differs from element count");

endmodule

// File: tb/sv/bounded_byte_set_table_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bounded byte set table: directed table, then random traffic.
module bounded_byte_set_table_unit_test;
	import bbst_pkg::*;

	localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
	localparam int MAX_IDLE        = 12;
	localparam int LONG_HOLD       = 400;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int DRAIN_CYCLES    = 12;
	localparam int BURSTS          = 14;
	localparam int BURST_LEN       = 100;
	localparam int POOL_SIZE       = 20;
	localparam int POOL_IDX_W      = $clog2(POOL_SIZE);
	localparam int DIRECTED_ROWS   = 27;

	typedef struct packed {
		logic              was_present;
		logic              changed;
		logic [SIZE_W-1:0] size_after;
	} set_response_t;

	typedef struct {
		logic [ACT_W-1:0] act;
		logic [VAL_W-1:0] val;
		bit               typed;
		set_response_t    outcome;
	} set_request_row_t;

	logic clk;
	logic arst_n;

	bbst_req_if req_ch();
	bbst_rsp_if rsp_ch();

	bounded_byte_set_table_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// set contents as the block should hold them
	logic [VAL_W-1:0] set_entries[CAPACITY];
	int               set_size;
	set_response_t    expected_responses[$];

	int  error_count;
	int  idle_cycles;
	int  rsp_hold_cycles;
	bit  recv_idle;
	bit  long_hold_req;
	int  requests_sent;
	int  responses_checked;
	int  action_counts[4];
	int  full_reached;
	int  emptied;
	int  refused_full_adds;

	set_request_row_t directed_rows[DIRECTED_ROWS] = '{
		'{ACT_LOOKUP, 8'h00, 1'b1, '{1'b0, 1'b0, 5'd0}},
		'{ACT_DELETE, 8'hFF, 1'b1, '{1'b0, 1'b0, 5'd0}},
		'{ACT_ADD,    8'h00, 1'b1, '{1'b0, 1'b1, 5'd1}},
		'{ACT_ADD,    8'hFF, 1'b1, '{1'b0, 1'b1, 5'd2}},
		'{ACT_ADD,    8'h00, 1'b1, '{1'b1, 1'b0, 5'd2}},
		'{ACT_SPARE,  8'hFF, 1'b1, '{1'b1, 1'b0, 5'd2}},
		'{ACT_SPARE,  8'hAA, 1'b1, '{1'b0, 1'b0, 5'd2}},
		'{ACT_DELETE, 8'h00, 1'b1, '{1'b1, 1'b1, 5'd1}},
		'{ACT_ADD,    8'h01, 1'b0, '{1'b0, 1'b0, 5'd0}},
		'{ACT_ADD,    8'h02, 1'b0, '{1'b0, 1'b0, 5'd0}},
		'{ACT_ADD,    8'h04, 1'b0, '{1'b0, 1'b0, 5'd0}},
		'{ACT_ADD,    8'h08, 1'b0, '{1'b0, 1'b0, 5'd0}},
		'{ACT_ADD,    8'h10, 1'b0, '{1'b0, 1'b0, 5'd0}},
		'{ACT_ADD,    8'h20, 1'b0, '{1'b0, 1'b0, 5'd0}},
		'{ACT_ADD,    8'h40, 1'b0, '{1'b0, 1'b0, 5'd0}},
		'{ACT_ADD,    8'h80, 1'b0, '{1'b0, 1'b0, 5'd0}},
		'{ACT_ADD,    8'h55, 1'b0, '{1'b0, 1'b0, 5'd0}},
		'{ACT_ADD,    8'hAA, 1'b0, '{1'b0, 1'b0, 5'd0}},
		'{ACT_ADD,    8'h0F, 1'b0, '{1'b0, 1'b0, 5'd0}},
		'{ACT_ADD,    8'hF0, 1'b0, '{1'b0, 1'b0, 5'd0}},
		'{ACT_ADD,    8'h33, 1'b0, '{1'b0, 1'b0, 5'd0}},
		'{ACT_ADD,    8'hCC, 1'b0, '{1'b0, 1'b0, 5'd0}},
		'{ACT_ADD,    8'hFE, 1'b1, '{1'b0, 1'b1, 5'd16}},
		'{ACT_ADD,    8'h7F, 1'b1, '{1'b0, 1'b0, 5'd16}},
		'{ACT_ADD,    8'h01, 1'b1, '{1'b1, 1'b0, 5'd16}},
		'{ACT_DELETE, 8'hFF, 1'b1, '{1'b1, 1'b1, 5'd15}},
		'{ACT_DELETE, 8'h10, 1'b0, '{1'b0, 1'b0, 5'd0}}
	};

	always #5 clk = ~clk;

	function automatic set_response_t apply_set_request(logic [ACT_W-1:0] act,
		logic [VAL_W-1:0] val);
		set_response_t r;
		int            pos;
		int            i;
		pos = -1;
		for (i = 0; i < set_size; i++) begin
			if (pos < 0 && set_entries[IDX_W'(i)] == val)
				pos = i;
		end
		r.was_present = (pos >= 0);
		r.changed     = 1'b0;
		unique case (act)
			ACT_ADD: begin
				if (pos < 0 && set_size < CAPACITY) begin
					set_entries[IDX_W'(set_size)] = val;
					set_size++;
					r.changed = 1'b1;
					if (set_size == CAPACITY)
						full_reached++;
				end else if (pos < 0) begin
					refused_full_adds++;
				end
			end
			ACT_DELETE: begin
				if (pos >= 0) begin
					for (i = pos; i < set_size - 1; i++)
						set_entries[IDX_W'(i)] = set_entries[IDX_W'(i + 1)];
					set_size--;
					r.changed = 1'b1;
					if (set_size == 0)
						emptied++;
				end
			end
			default: ;
		endcase
		r.size_after = SIZE_W'(set_size);
		return r;
	endfunction

	// offer one transaction after a gap, wait for acceptance, record its expected response
	task automatic send_request(input logic [ACT_W-1:0] act, input logic [VAL_W-1:0] val,
		input int gap, input bit typed, input set_response_t typed_outcome);
		set_response_t predicted;
		if (gap > 0) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid  <= 1'b1;
		req_ch.action <= act;
		req_ch.value  <= val;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		predicted = apply_set_request(act, val);
		expected_responses.push_back(typed ? typed_outcome : predicted);
		requests_sent++;
		action_counts[act]++;
	endtask

	// response side: stall counted here, long hold on request
	always @(negedge clk) begin
		if (long_hold_req) begin
			rsp_hold_cycles = LONG_HOLD;
			long_hold_req   = 1'b0;
		end
		if (rsp_hold_cycles > 0) begin
			rsp_ch.ready <= 1'b0;
			rsp_hold_cycles--;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		set_response_t got;
		set_response_t want;
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				got = '{rsp_ch.was_present, rsp_ch.changed, rsp_ch.size_after};
				rsp_hold_cycles = recv_idle ? $urandom_range(0, MAX_IDLE) : 0;
				if (expected_responses.size() == 0) begin
					$error("unexpected response transaction: was_present %0d changed %0d size_after %0d",
						got.was_present, got.changed, got.size_after);
					error_count++;
				end else begin
					want = expected_responses.pop_front();
					responses_checked++;
					if (got.was_present !== want.was_present) begin
						$error("was_present: expected %0d, got %0d", want.was_present,
							got.was_present);
						error_count++;
					end
					if (got.changed !== want.changed) begin
						$error("changed: expected %0d, got %0d", want.changed, got.changed);
						error_count++;
					end
					if (got.size_after !== want.size_after) begin
						$error("size_after: expected %0d, got %0d", want.size_after,
							got.size_after);
						error_count++;
					end
				end
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$error("no transaction for %0d cycles, %0d responses outstanding",
					idle_cycles, expected_responses.size());
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		logic [VAL_W-1:0] value_pool[POOL_SIZE];
		logic [ACT_W-1:0] act;
		logic [VAL_W-1:0] val;
		bit               send_idle;
		int               mode;
		int               roll;
		int               b;
		int               n;
		clk             = 1'b0;
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.action   = ACT_LOOKUP;
		req_ch.value    = '0;
		rsp_ch.ready    = 1'b0;
		rsp_hold_cycles = 0;
		recv_idle       = 1'b1;
		long_hold_req   = 1'b0;
		set_size        = 0;
		error_count     = 0;
		idle_cycles     = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[r])
			send_request(directed_rows[r].act, directed_rows[r].val,
				$urandom_range(0, MAX_IDLE), directed_rows[r].typed, directed_rows[r].outcome);

		for (b = 0; b < BURSTS; b++) begin
			// fill-heavy, drain-heavy or balanced, over a small pool so hits are common
			mode      = $urandom_range(0, 2);
			send_idle = ($urandom_range(0, 3) != 0);
			recv_idle = ($urandom_range(0, 3) != 0);
			foreach (value_pool[p])
				value_pool[p] = VAL_W'($urandom_range(0, 255));
			if (b == 3) begin
				send_idle     = 1'b0;
				long_hold_req = 1'b1;
			end
			if (b == 6 || $urandom_range(0, 3) == 0) begin
				@(negedge clk);
				req_ch.valid <= 1'b0;
				wait (expected_responses.size() == 0);
			end
			for (n = 0; n < BURST_LEN; n++) begin
				roll = $urandom_range(0, 99);
				unique case (mode)
					0:       act = roll < 55 ? ACT_ADD : roll < 75 ? ACT_DELETE :
						roll < 95 ? ACT_LOOKUP : ACT_SPARE;
					1:       act = roll < 25 ? ACT_ADD : roll < 70 ? ACT_DELETE :
						roll < 95 ? ACT_LOOKUP : ACT_SPARE;
					default: act = roll < 40 ? ACT_ADD : roll < 70 ? ACT_DELETE :
						roll < 95 ? ACT_LOOKUP : ACT_SPARE;
				endcase
				val = ($urandom_range(0, 9) < 8) ?
					value_pool[POOL_IDX_W'($urandom_range(0, POOL_SIZE - 1))] :
					8'($urandom_range(0, 255));
				send_request(act, val, send_idle ? $urandom_range(0, MAX_IDLE) : 0, 1'b0, '0);
			end
		end

		@(negedge clk);
		req_ch.valid <= 1'b0;
		wait (expected_responses.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests (%0d lookups, %0d adds, %0d deletes, %0d spare code), %0d responses checked",
			requests_sent, action_counts[ACT_LOOKUP], action_counts[ACT_ADD],
			action_counts[ACT_DELETE], action_counts[ACT_SPARE], responses_checked);
		$display("set filled %0d times, emptied %0d times, %0d adds refused while full",
			full_reached, emptied, refused_full_adds);
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// File: bounded_byte_set_table_unit.f
design/bbst_pkg.sv
design/bbst_if.sv
design/bbst_ctrl.sv
design/bbst_dpath.sv
design/bounded_byte_set_table_unit.sv
tb/sv/bounded_byte_set_table_unit_test.sv
